### hdl/uarw_pkg.sv
// shared types and constants of the usb audio ring writer
package uarw_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int FIELD_SLOT_W  = 11;
    localparam int SAMPLE_W      = 24;
    localparam int WORD_W        = 32;
    localparam int FEEDBACK_W    = 24;
    localparam int RATE_W        = 17;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        RATE_44K1 = 2'd0,
        RATE_48K  = 2'd1,
        RATE_88K2 = 2'd2,
        RATE_96K  = 2'd3
    } t_rate;

    localparam logic [RATE_W-1:0] RATE_HZ_44K1 = 17'd44100;
    localparam logic [RATE_W-1:0] RATE_HZ_48K  = 17'd48000;
    localparam logic [RATE_W-1:0] RATE_HZ_88K2 = 17'd88200;
    localparam logic [RATE_W-1:0] RATE_HZ_96K  = 17'd96000;

    // feedback band: ring nearly full, middle third, nearly empty
    typedef enum logic [1:0] {
        BAND_SLOWER = 2'd0,
        BAND_NOMINAL = 2'd1,
        BAND_FASTER = 2'd2
    } t_band;

    // kHz << 14 | (Hz mod 1000) << 4 for rate - 100, rate, rate + 100
    localparam logic [FEEDBACK_W-1:0] FEEDBACK_CODE [4][3] = '{
        '{24'h0B0000, 24'h0B0640, 24'h0B0C80},
        '{24'h0BF840, 24'h0C0000, 24'h0C0640},
        '{24'h160640, 24'h160C80, 24'h1612C0},
        '{24'h17F840, 24'h180000, 24'h180640}
    };

    typedef struct packed {
        t_op                     op;
        logic [WORD_W-1:0]       left_word;
        logic [WORD_W-1:0]       right_word;
        logic                    last;
        logic [FIELD_SLOT_W-1:0] play_position;
        logic                    playing;
    } t_item;

    typedef struct packed {
        logic [FIELD_SLOT_W-1:0] store_index;
        logic [WORD_W-1:0]       left_word;
        logic [WORD_W-1:0]       right_word;
        logic                    stored;
        logic                    overrun;
        logic [WORD_W-1:0]       overrun_total;
        logic                    packet_done;
        logic [FIELD_SLOT_W-1:0] fill_level;
        logic [FEEDBACK_W-1:0]   feedback_value;
        logic                    start_playback;
    } t_result;

endpackage

### hdl/uarw_queue.sv
// small first-in first-out queue used between the pipeline parts
module uarw_queue import uarw_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### hdl/uarw_front.sv
// front end: takes requests, repacks samples and queues them for the back end
module uarw_front import uarw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_operation,
    input  logic [SAMPLE_W-1:0]     i_left_sample,
    input  logic [SAMPLE_W-1:0]     i_right_sample,
    input  logic                    i_last_in_packet,
    input  logic [FIELD_SLOT_W-1:0] i_play_position,
    input  logic                    i_playing,
    output t_item                   o_item,
    output logic                    o_item_valid,
    input  logic                    i_item_pop
);

    // low byte to the top, high byte to 15:8, middle byte to 7:0
    function automatic logic [WORD_W-1:0] repack(input logic [SAMPLE_W-1:0] s);
        return {s[7:0], 8'h00, s[23:16], s[15:8]};
    endfunction

    t_item            item;
    logic [$bits(t_item)-1:0] rd_data;
    logic             empty;

    always_comb begin
        item               = '0;
        item.op            = t_op'(i_operation);
        item.last          = i_last_in_packet;
        item.play_position = i_play_position;
        item.playing       = i_playing;
        if (item.op == OP_FRAME) begin
            item.left_word  = repack(i_left_sample);
            item.right_word = repack(i_right_sample);
        end
    end

    uarw_queue #(
        .WIDTH ($bits(t_item))
    ) u_item_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_wr_data (item),
        .o_full    (o_full),
        .i_pop     (i_item_pop),
        .o_rd_data (rd_data),
        .o_empty   (empty)
    );

    assign o_item       = t_item'(rd_data);
    assign o_item_valid = !empty;

endmodule

### hdl/uarw_back.sv
// back end: ring position, overrun tracking, fill level and rate feedback
module uarw_back import uarw_pkg::*; #(
    parameter int BUFFER_WORDS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [RATE_W-1:0] i_cfg_data,
    input  t_item             i_item,
    input  logic              i_item_valid,
    output logic              o_item_pop,
    input  logic              i_res_full,
    output t_result           o_result,
    output logic              o_res_push
);

    // write position runs up to BUFFER_WORDS + 1
    localparam int PW  = $clog2(BUFFER_WORDS + 2);
    localparam int AW  = ((PW > FIELD_SLOT_W) ? PW : FIELD_SLOT_W) + 2;
    localparam logic [AW-1:0] BW_A      = AW'(BUFFER_WORDS);
    localparam logic [AW-1:0] HALF_A    = AW'(BUFFER_WORDS / 2);
    localparam logic [AW-1:0] THIRD_A   = AW'(BUFFER_WORDS / 3);
    localparam logic [AW-1:0] TWO_3RD_A = AW'((BUFFER_WORDS / 3) * 2);

    logic [PW-1:0]     r_write_pos, n_write_pos;
    logic [WORD_W-1:0] r_overrun_count, n_overrun_count;
    logic              r_dropping, n_dropping;
    t_rate             r_rate, n_rate;

    logic          fire;
    logic [AW-1:0] wp_a, play_a, next_slot, new_wp, fill;
    logic          hit, do_store;
    t_band         band;
    t_result       res;

    assign fire       = i_item_valid && !i_res_full;
    assign o_item_pop = fire;
    assign o_res_push = fire;
    assign o_result   = res;

    always_comb begin
        n_rate = r_rate;
        if (i_cfg_valid) begin
            unique case (i_cfg_data)
                RATE_HZ_44K1: n_rate = RATE_44K1;
                RATE_HZ_48K:  n_rate = RATE_48K;
                RATE_HZ_88K2: n_rate = RATE_88K2;
                RATE_HZ_96K:  n_rate = RATE_96K;
                default:      n_rate = r_rate;
            endcase
        end
    end

    always_comb begin
        wp_a      = AW'(r_write_pos);
        play_a    = AW'(i_item.play_position);
        next_slot = (wp_a < BW_A) ? wp_a + AW'(2) : '0;
        hit       = !r_dropping && (next_slot == play_a);
        do_store  = !r_dropping && !hit;
        new_wp    = do_store ? next_slot : wp_a;

        if (new_wp > play_a) begin
            fill = new_wp - play_a;
        end else if (play_a > BW_A + new_wp) begin
            fill = '0;
        end else begin
            fill = BW_A - play_a + new_wp;
        end

        priority if (fill > TWO_3RD_A) begin
            band = BAND_SLOWER;
        end else if (fill > THIRD_A) begin
            band = BAND_NOMINAL;
        end else begin
            band = BAND_FASTER;
        end

        res             = '0;
        n_write_pos     = r_write_pos;
        n_overrun_count = r_overrun_count;
        n_dropping      = r_dropping;

        if (i_item.op == OP_FLUSH) begin
            n_write_pos     = '0;
            n_overrun_count = '0;
            n_dropping      = 1'b0;
        end else begin
            n_write_pos     = new_wp[PW-1:0];
            n_overrun_count = r_overrun_count + WORD_W'(hit);
            n_dropping      = (r_dropping || hit) && !i_item.last;
            res.overrun       = hit;
            res.overrun_total = n_overrun_count;
            if (do_store) begin
                res.stored      = 1'b1;
                res.store_index = next_slot[FIELD_SLOT_W-1:0];
                res.left_word   = i_item.left_word;
                res.right_word  = i_item.right_word;
            end
            if (i_item.last) begin
                res.packet_done    = 1'b1;
                res.fill_level     = fill[FIELD_SLOT_W-1:0];
                res.start_playback = !i_item.playing && (fill > HALF_A);
                res.feedback_value = FEEDBACK_CODE[r_rate][band];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos     <= '0;
            r_overrun_count <= '0;
            r_dropping      <= 1'b0;
            r_rate          <= RATE_44K1;
        end else begin
            r_rate <= n_rate;
            if (fire) begin
                r_write_pos     <= n_write_pos;
                r_overrun_count <= n_overrun_count;
                r_dropping      <= n_dropping;
            end
        end
    end

endmodule

### hdl/usb_audio_ring_writer_feedback.sv
// Ring writer for USB audio OUT frames with asynchronous rate feedback. Each request is
// either a stereo frame or a flush; frames are repacked and, unless dropped as an overrun,
// given the next even ring slot, and the last frame of a packet also reports fill level, a
// feedback word and a playback start request. One request is taken every clock cycle when
// the result side keeps popping. A two-entry input queue feeds a combinational back end
// that updates the write position and overrun count and pushes each result into a
// two-entry result queue, which lets either side stall alone. The sample rate register
// takes only 44100, 48000, 88200 or 96000; any other written value is ignored. Write it
// only while no request is in flight.
module usb_audio_ring_writer_feedback import uarw_pkg::*; #(
    parameter int BUFFER_WORDS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_operation,
    input  logic [SAMPLE_W-1:0]     i_left_sample,
    input  logic [SAMPLE_W-1:0]     i_right_sample,
    input  logic                    i_last_in_packet,
    input  logic [FIELD_SLOT_W-1:0] i_play_position,
    input  logic                    i_playing,
    output logic                    empty,
    input  logic                    pop,
    output logic [FIELD_SLOT_W-1:0] o_store_index,
    output logic [WORD_W-1:0]       o_left_word,
    output logic [WORD_W-1:0]       o_right_word,
    output logic                    o_stored,
    output logic                    o_overrun,
    output logic [WORD_W-1:0]       o_overrun_total,
    output logic                    o_packet_done,
    output logic [FIELD_SLOT_W-1:0] o_fill_level,
    output logic [FEEDBACK_W-1:0]   o_feedback_value,
    output logic                    o_start_playback,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [RATE_W-1:0]       i_cfg_data
);

    t_item   item;
    logic    item_valid, item_pop;
    t_result result, out_res;
    logic    res_push, res_full;
    logic [$bits(t_result)-1:0] out_data;

    assign o_cfg_ready = 1'b1;

    uarw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_operation      (i_operation),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_last_in_packet (i_last_in_packet),
        .i_play_position  (i_play_position),
        .i_playing        (i_playing),
        .o_item           (item),
        .o_item_valid     (item_valid),
        .i_item_pop       (item_pop)
    );

    uarw_back #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_result     (result),
        .o_res_push   (res_push)
    );

    uarw_queue #(
        .WIDTH ($bits(t_result))
    ) u_result_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_push),
        .i_wr_data (result),
        .o_full    (res_full),
        .i_pop     (pop),
        .o_rd_data (out_data),
        .o_empty   (empty)
    );

    assign out_res          = t_result'(out_data);
    assign o_store_index    = out_res.store_index;
    assign o_left_word      = out_res.left_word;
    assign o_right_word     = out_res.right_word;
    assign o_stored         = out_res.stored;
    assign o_overrun        = out_res.overrun;
    assign o_overrun_total  = out_res.overrun_total;
    assign o_packet_done    = out_res.packet_done;
    assign o_fill_level     = out_res.fill_level;
    assign o_feedback_value = out_res.feedback_value;
    assign o_start_playback = out_res.start_playback;

endmodule

### hdl/uarw_checker.sv
// port-level checks on the ring writer, bound to the top level
module uarw_checker import uarw_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic [FIELD_SLOT_W-1:0] o_store_index,
    input logic [WORD_W-1:0]       o_left_word,
    input logic [WORD_W-1:0]       o_right_word,
    input logic                    o_stored,
    input logic                    o_overrun,
    input logic [WORD_W-1:0]       o_overrun_total,
    input logic                    o_packet_done,
    input logic [FIELD_SLOT_W-1:0] o_fill_level,
    input logic [FEEDBACK_W-1:0]   o_feedback_value,
    input logic                    o_start_playback
);

    // a result never marks a frame both stored and overrun
    a_store_xor_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_stored && o_overrun))
        else $error("result both stored and overrun");

    // an overrun means the running count is non-zero
    a_overrun_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_overrun) |-> (o_overrun_total != '0))
        else $error("overrun reported with zero total");

    // start request, fill and feedback only come with a packet end
    a_start_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_packet_done) |->
            (!o_start_playback && o_fill_level == '0 && o_feedback_value == '0))
        else $error("packet report fields set outside a packet end");

    // nothing stored means no slot and no words
    a_unstored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_stored) |->
            (o_store_index == '0 && o_left_word == '0 && o_right_word == '0))
        else $error("slot or words set on an unstored result");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_overrun_total) && $stable(o_left_word)))
        else $error("waiting result changed before pop");

endmodule

bind usb_audio_ring_writer_feedback uarw_checker u_checker (.*);

### test/testbench.sv
// testbench for the usb audio ring writer: predicted results checked against every popped result
`timescale 1ns / 1ps

module testbench;
    import uarw_pkg::*;

    localparam int BUFFER_WORDS = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic                    i_operation = OP_FRAME;
    logic [SAMPLE_W-1:0]     i_left_sample = '0;
    logic [SAMPLE_W-1:0]     i_right_sample = '0;
    logic                    i_last_in_packet = 1'b0;
    logic [FIELD_SLOT_W-1:0] i_play_position = '0;
    logic                    i_playing = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [FIELD_SLOT_W-1:0] o_store_index;
    logic [WORD_W-1:0]       o_left_word;
    logic [WORD_W-1:0]       o_right_word;
    logic                    o_stored;
    logic                    o_overrun;
    logic [WORD_W-1:0]       o_overrun_total;
    logic                    o_packet_done;
    logic [FIELD_SLOT_W-1:0] o_fill_level;
    logic [FEEDBACK_W-1:0]   o_feedback_value;
    logic                    o_start_playback;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [RATE_W-1:0]       i_cfg_data = '0;

    usb_audio_ring_writer_feedback #(
        .BUFFER_WORDS(BUFFER_WORDS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_left_sample   (i_left_sample),
        .i_right_sample  (i_right_sample),
        .i_last_in_packet(i_last_in_packet),
        .i_play_position (i_play_position),
        .i_playing       (i_playing),
        .empty           (empty),
        .pop             (pop),
        .o_store_index   (o_store_index),
        .o_left_word     (o_left_word),
        .o_right_word    (o_right_word),
        .o_stored        (o_stored),
        .o_overrun       (o_overrun),
        .o_overrun_total (o_overrun_total),
        .o_packet_done   (o_packet_done),
        .o_fill_level    (o_fill_level),
        .o_feedback_value(o_feedback_value),
        .o_start_playback(o_start_playback),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predicted ring state
    logic [RATE_W-1:0] rate_hz = RATE_HZ_44K1;
    int unsigned       ring_pos = 0;
    logic [WORD_W-1:0] overrun_seen = '0;
    bit                dropping = 1'b0;

    t_result pending_results[$];
    int      mismatches = 0;
    int      cycle_count = 0;

    // sender pacing
    int burst_left = 1;
    int gap_max = 2;
    int pkt_left = 0;

    // receiver pacing
    int rx_mode = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;
    int run_left = 0;

    function automatic logic [WORD_W-1:0] repack_sample(logic [SAMPLE_W-1:0] s);
        return {s[7:0], 8'h00, s[23:16], s[15:8]};
    endfunction

    function automatic logic [FEEDBACK_W-1:0] feedback_code(int unsigned hz);
        int unsigned khz;
        int unsigned rem;
        khz = hz / 1000;
        rem = hz % 1000;
        return FEEDBACK_W'((khz << 14) | (rem << 4));
    endfunction

    function automatic t_result ring_write_outcome(t_op op, logic [SAMPLE_W-1:0] l,
                                                   logic [SAMPLE_W-1:0] r, logic last,
                                                   logic [FIELD_SLOT_W-1:0] play,
                                                   logic playing);
        t_result     res;
        int unsigned next_slot;
        int unsigned fill;
        int unsigned rate;
        res = '0;
        if (op == OP_FLUSH) begin
            ring_pos = 0;
            overrun_seen = '0;
            dropping = 1'b0;
            return res;
        end
        if (!dropping) begin
            next_slot = (ring_pos < BUFFER_WORDS) ? ring_pos + 2 : 0;
            if (next_slot != play) begin
                ring_pos = next_slot;
                res.store_index = next_slot[FIELD_SLOT_W-1:0];
                res.left_word = repack_sample(l);
                res.right_word = repack_sample(r);
                res.stored = 1'b1;
            end else begin
                overrun_seen = overrun_seen + 1;
                res.overrun = 1'b1;
                dropping = 1'b1;
            end
        end
        res.overrun_total = overrun_seen;
        if (last) begin
            dropping = 1'b0;
            res.packet_done = 1'b1;
            if (ring_pos > play)
                fill = ring_pos - play;
            else if (play > BUFFER_WORDS + ring_pos)
                fill = 0;
            else
                fill = BUFFER_WORDS - play + ring_pos;
            res.fill_level = fill[FIELD_SLOT_W-1:0];
            res.start_playback = (!playing && fill > BUFFER_WORDS / 2);
            // ring nearly full asks the host to slow down
            if (fill > (BUFFER_WORDS / 3) * 2)
                rate = rate_hz - 100;
            else if (fill > BUFFER_WORDS / 3)
                rate = rate_hz;
            else
                rate = rate_hz + 100;
            res.feedback_value = feedback_code(rate);
        end
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, actual index %0h",
                         $time, o_store_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("store_index", 32'(want.store_index), 32'(o_store_index));
                compare_field("left_word", want.left_word, o_left_word);
                compare_field("right_word", want.right_word, o_right_word);
                compare_field("stored", 32'(want.stored), 32'(o_stored));
                compare_field("overrun", 32'(want.overrun), 32'(o_overrun));
                compare_field("overrun_total", want.overrun_total, o_overrun_total);
                compare_field("packet_done", 32'(want.packet_done), 32'(o_packet_done));
                compare_field("fill_level", 32'(want.fill_level), 32'(o_fill_level));
                compare_field("feedback_value", 32'(want.feedback_value),
                              32'(o_feedback_value));
                compare_field("start_playback", 32'(want.start_playback),
                              32'(o_start_playback));
            end
        end
    end

    // receiver: runs of pop/stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_ticket) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            run_left <= $urandom_range(0, 7);
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(t_op op, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                             logic last, logic [FIELD_SLOT_W-1:0] play, logic playing);
        i_operation <= op;
        i_left_sample <= l;
        i_right_sample <= r;
        i_last_in_packet <= last;
        i_play_position <= play;
        i_playing <= playing;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        pending_results.push_back(ring_write_outcome(op, l, r, last, play, playing));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_random(int flush_pct, int overrun_pct);
        t_op                     op;
        logic [SAMPLE_W-1:0]     l;
        logic [SAMPLE_W-1:0]     r;
        logic                    last;
        logic [FIELD_SLOT_W-1:0] play;
        int unsigned             pick;
        int unsigned             next_slot;
        op = ($urandom_range(0, 99) < flush_pct) ? OP_FLUSH : OP_FRAME;
        pick = $urandom_range(0, 15);
        l = (pick == 0) ? '0 : (pick == 1) ? '1 : SAMPLE_W'($urandom());
        pick = $urandom_range(0, 15);
        r = (pick == 0) ? '0 : (pick == 1) ? '1 : SAMPLE_W'($urandom());
        if (pkt_left == 0)
            pkt_left = $urandom_range(1, 12);
        last = (pkt_left == 1);
        pkt_left--;
        // broken packet framing now and then
        if ($urandom_range(0, 99) < 4)
            last = ~last;
        next_slot = (ring_pos < BUFFER_WORDS) ? ring_pos + 2 : 0;
        pick = $urandom_range(0, 99);
        if (pick < overrun_pct)
            play = next_slot[FIELD_SLOT_W-1:0];
        else if (pick < overrun_pct + 8)
            play = FIELD_SLOT_W'($urandom_range(0, 2047));
        else
            play = FIELD_SLOT_W'(2 * $urandom_range(0, BUFFER_WORDS / 2));
        send_item(op, l, r, last, play, 1'($urandom_range(0, 1)));
    endtask

    // wait until every request has its result, then let the pipeline drain
    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [RATE_W-1:0] value);
        settle();
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (value == RATE_HZ_44K1 || value == RATE_HZ_48K || value == RATE_HZ_88K2
            || value == RATE_HZ_96K)
            rate_hz = value;
    endtask

    task automatic test_directed();
        send_item(OP_FRAME, 24'h000000, 24'h000000, 1'b0, 11'd1024, 1'b0);
        send_item(OP_FRAME, 24'hffffff, 24'hffffff, 1'b1, 11'd0, 1'b0);
        // play position past the ring end gives a fill level of zero
        send_item(OP_FRAME, 24'h123456, 24'habcdef, 1'b1, 11'd2047, 1'b1);
        send_item(OP_FRAME, 24'h5a5a5a, 24'ha5a5a5, 1'b1, 11'd1024, 1'b0);
        // hit the play position mid packet, then the rest is dropped
        send_item(OP_FRAME, 24'h010203, 24'h040506, 1'b0, 11'd10, 1'b0);
        send_item(OP_FRAME, 24'h0f0f0f, 24'hf0f0f0, 1'b0, 11'd10, 1'b1);
        send_item(OP_FRAME, 24'h800000, 24'h000001, 1'b1, 11'd10, 1'b0);
        // overrun on the last frame itself
        send_item(OP_FRAME, 24'h7fffff, 24'h800000, 1'b1, 11'd10, 1'b1);
        send_item(OP_FRAME, 24'h00ff00, 24'hff00ff, 1'b1, 11'd500, 1'b0);
        // write position equal to play position reads as a full ring
        send_item(OP_FRAME, 24'h111111, 24'h222222, 1'b0, 11'd12, 1'b0);
        send_item(OP_FRAME, 24'h333333, 24'h444444, 1'b1, 11'd10, 1'b0);
        send_item(OP_FLUSH, 24'hffffff, 24'hffffff, 1'b1, 11'd2047, 1'b1);
        send_item(OP_FRAME, 24'hc0ffee, 24'hbeef00, 1'b1, 11'd2, 1'b0);
        send_item(OP_FRAME, 24'h000000, 24'hffffff, 1'b1, 11'd700, 1'b1);
        send_item(OP_FLUSH, 24'h000000, 24'h000000, 1'b0, 11'd0, 1'b0);
        send_item(OP_FRAME, 24'hffffff, 24'h000000, 1'b1, 11'd340, 1'b0);
    endtask

    task automatic test_rate_register();
        logic [RATE_W-1:0] rates [8];
        rates = '{RATE_HZ_48K, 17'd12345, RATE_HZ_96K, 17'd0, 17'h1ffff,
                  RATE_HZ_88K2, 17'd44101, RATE_HZ_44K1};
        foreach (rates[i]) begin
            write_rate(rates[i]);
            repeat (3)
                send_item(OP_FRAME, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), 1'b1,
                          FIELD_SLOT_W'(2 * $urandom_range(0, BUFFER_WORDS / 2)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_ring_wrap();
        write_rate(RATE_HZ_96K);
        rx_mode <= 1;
        gap_max = 3;
        repeat (700) send_random(0, 2);
    endtask

    task automatic test_backpressure();
        settle();
        hold_ticket <= hold_ticket + 1;
        gap_max = 0;
        repeat (40) send_random(0, 5);
        gap_max = 6;
    endtask

    task automatic test_random_traffic();
        int modes [4];
        int gaps [4];
        modes = '{0, 1, 2, 1};
        gaps = '{0, 4, 8, 2};
        foreach (modes[i]) begin
            if (i == 2)
                write_rate(RATE_HZ_88K2);
            rx_mode <= modes[i];
            gap_max = gaps[i];
            repeat (110) send_random(2, 10);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_rate_register();
        test_ring_wrap();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0t: %0d mismatches, %0d results missing", $time, mismatches,
                     pending_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
hdl/uarw_pkg.sv
hdl/uarw_queue.sv
hdl/uarw_front.sv
hdl/uarw_back.sv
hdl/usb_audio_ring_writer_feedback.sv
hdl/uarw_checker.sv
test/testbench.sv
